FILE: design/qrm_pkg.sv
// Shared widths, defaults and types for the quaternion to rotation matrix core.
package qrm_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;

  // Scaled components have magnitude at most 2^15 and are held signed.
  localparam int          SC_W    = 17;
  localparam int          MAG_W   = 16;
  localparam logic [15:0] MAG_LIM = 16'd32768;
  // Products: magnitude at most 2^30.
  localparam int PROD_W  = 32;
  // Numerators: off-diagonal magnitude up to 2^32.
  localparam int NUM_W   = 34;
  // Norm and numerator magnitudes: at most 2^32.
  localparam int N_W     = 33;
  localparam int OUT_W   = 16;
  localparam int N_ENTRY = 9;

  typedef struct packed {
    logic signed [SC_W-1:0] x;
    logic signed [SC_W-1:0] y;
    logic signed [SC_W-1:0] z;
    logic signed [SC_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic [N_ENTRY-1:0][N_W-1:0] mag;
    logic [N_ENTRY-1:0]          neg;
    logic [N_W-1:0]              norm;
  } frac_t;

endpackage

FILE: design/qrm_prep.sv
// Input register and common right shift that brings all magnitudes to at most 2^15.
module qrm_prep import qrm_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic [IN_WIDTH-1:0] comp_x_i,
  input  logic [IN_WIDTH-1:0] comp_y_i,
  input  logic [IN_WIDTH-1:0] comp_z_i,
  input  logic [IN_WIDTH-1:0] comp_w_i,
  output quat_t               quat_o
);

  localparam int EXT_W = (IN_WIDTH > MAG_W) ? IN_WIDTH : MAG_W;
  localparam int MAX_K = EXT_W - MAG_W;
  localparam int KW    = $clog2(MAX_K + 2);

  logic [3:0][IN_WIDTH-1:0] raw_q;
  logic [3:0][EXT_W-1:0]    ext;
  logic [EXT_W-1:0]         mx;
  logic [KW-1:0]            shamt;
  logic [3:0][SC_W-1:0]     sc;
  quat_t                    quat_d, quat_q;

  always_ff @(posedge clk_i) begin
    raw_q <= {comp_w_i, comp_z_i, comp_y_i, comp_x_i};
  end

  always_comb begin
    logic [IN_WIDTH-1:0] m;
    logic [EXT_W-1:0]    s;
    mx = '0;
    for (int i = 0; i < 4; i++) begin
      m      = raw_q[i][IN_WIDTH-1] ? (~raw_q[i] + 1'b1) : raw_q[i];
      ext[i] = EXT_W'(m);
      if (ext[i] > mx) mx = ext[i];
    end
    // Smallest shift wins: scan from the largest down.
    shamt = KW'(MAX_K);
    for (int j = MAX_K; j >= 0; j--) begin
      if ((mx >> j) <= EXT_W'(MAG_LIM)) shamt = KW'(j);
    end
    for (int i = 0; i < 4; i++) begin
      s     = ext[i] >> shamt;
      sc[i] = raw_q[i][IN_WIDTH-1] ? (SC_W'(0) - {1'b0, s[MAG_W-1:0]})
                                   : {1'b0, s[MAG_W-1:0]};
    end
    quat_d.x = sc[0];
    quat_d.y = sc[1];
    quat_d.z = sc[2];
    quat_d.w = sc[3];
  end

  always_ff @(posedge clk_i) begin
    quat_q <= quat_d;
  end

  assign quat_o = quat_q;

endmodule

FILE: design/qrm_prod.sv
// Products, norm and the nine numerators as sign and magnitude, two register stages.
module qrm_prod import qrm_pkg::*; (
  input  logic  clk_i,
  input  quat_t quat_i,
  output frac_t frac_o
);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  function automatic prod_t mul(input logic signed [SC_W-1:0] a,
                                input logic signed [SC_W-1:0] b);
    logic signed [2*SC_W-1:0] p;
    p = a * b;
    return p[PROD_W-1:0];
  endfunction

  prod_t xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, xz_q, yw_q, yz_q, xw_q;

  always_ff @(posedge clk_i) begin
    xx_q <= mul(quat_i.x, quat_i.x);
    yy_q <= mul(quat_i.y, quat_i.y);
    zz_q <= mul(quat_i.z, quat_i.z);
    ww_q <= mul(quat_i.w, quat_i.w);
    xy_q <= mul(quat_i.x, quat_i.y);
    zw_q <= mul(quat_i.z, quat_i.w);
    xz_q <= mul(quat_i.x, quat_i.z);
    yw_q <= mul(quat_i.y, quat_i.w);
    yz_q <= mul(quat_i.y, quat_i.z);
    xw_q <= mul(quat_i.x, quat_i.w);
  end

  num_t  exx, eyy, ezz, eww, exy, ezw, exz, eyw, eyz, exw;
  num_t  num [N_ENTRY];
  num_t  nrm;
  frac_t frac_d, frac_q;

  always_comb begin
    num_t a;
    exx = NUM_W'(xx_q);
    eyy = NUM_W'(yy_q);
    ezz = NUM_W'(zz_q);
    eww = NUM_W'(ww_q);
    exy = NUM_W'(xy_q);
    ezw = NUM_W'(zw_q);
    exz = NUM_W'(xz_q);
    eyw = NUM_W'(yw_q);
    eyz = NUM_W'(yz_q);
    exw = NUM_W'(xw_q);
    num[0] = exx + eww - eyy - ezz;
    num[1] = (exy - ezw) <<< 1;
    num[2] = (exz + eyw) <<< 1;
    num[3] = (exy + ezw) <<< 1;
    num[4] = eyy + eww - exx - ezz;
    num[5] = (eyz - exw) <<< 1;
    num[6] = (exz - eyw) <<< 1;
    num[7] = (eyz + exw) <<< 1;
    num[8] = ezz + eww - exx - eyy;
    nrm    = exx + eyy + ezz + eww;
    for (int i = 0; i < N_ENTRY; i++) begin
      a               = num[i][NUM_W-1] ? -num[i] : num[i];
      frac_d.mag[i]   = a[N_W-1:0];
      frac_d.neg[i]   = num[i][NUM_W-1];
    end
    frac_d.norm = nrm[N_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
  end

  assign frac_o = frac_q;

endmodule

FILE: design/qrm_div.sv
// Pipelined restoring divider: floor(mag * 2^(FRAC_BITS+1) / norm), one bit per stage.
module qrm_div import qrm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic [N_W-1:0]       mag_i,
  input  logic [N_W-1:0]       norm_i,
  input  logic                 neg_i,
  output logic [FRAC_BITS+1:0] quo_o,
  output logic                 neg_o
);

  localparam int NS = FRAC_BITS + 2;

  logic [N_W-1:0]       rem_q [NS];
  logic [N_W-1:0]       den_q [NS];
  logic [FRAC_BITS+1:0] quo_q [NS];
  logic                 neg_q [NS];

  // The magnitude never exceeds the norm, so the top bit is a single compare.
  always_ff @(posedge clk_i) begin
    if (mag_i >= norm_i) begin
      rem_q[0] <= mag_i - norm_i;
      quo_q[0] <= (FRAC_BITS+2)'(1);
    end else begin
      rem_q[0] <= mag_i;
      quo_q[0] <= '0;
    end
    den_q[0] <= norm_i;
    neg_q[0] <= neg_i;
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [N_W:0] dbl;
    logic [N_W:0] dif;
    assign dbl = {rem_q[s-1], 1'b0};
    assign dif = dbl - {1'b0, den_q[s-1]};

    always_ff @(posedge clk_i) begin
      if (dbl >= {1'b0, den_q[s-1]}) begin
        rem_q[s] <= dif[N_W-1:0];
        quo_q[s] <= {quo_q[s-1][FRAC_BITS:0], 1'b1};
      end else begin
        rem_q[s] <= dbl[N_W-1:0];
        quo_q[s] <= {quo_q[s-1][FRAC_BITS:0], 1'b0};
      end
      den_q[s] <= den_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
  end

  assign quo_o = quo_q[NS-1];
  assign neg_o = neg_q[NS-1];

endmodule

FILE: design/quaternion_to_rotation_matrix_core.sv
// Top level: quaternion in, nine rotation matrix entries out, fully pipelined.
//
//  channel   direction  handshake                 payload
//  command   in         start_i, busy_o           comp_x_i comp_y_i comp_z_i comp_w_i
//  result    out        result_valid_o (strobe)   r11_o .. r33_o, zero_input_o
//
// One transaction enters per cycle; busy_o stays low.
// Pipeline registers: input, shift, products, sums, FRAC_BITS + 2
// divider stages (one quotient bit each) and the output register.
// Reset clears only the valid and zero-flag shift registers; data registers and zero_q run free.
// The result strobe lasts one cycle and the receiver cannot stall it.
module quaternion_to_rotation_matrix_core import qrm_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [IN_WIDTH-1:0] comp_x_i,
  input  logic [IN_WIDTH-1:0] comp_y_i,
  input  logic [IN_WIDTH-1:0] comp_z_i,
  input  logic [IN_WIDTH-1:0] comp_w_i,
  output logic                result_valid_o,
  output logic [OUT_W-1:0]    r11_o,
  output logic [OUT_W-1:0]    r12_o,
  output logic [OUT_W-1:0]    r13_o,
  output logic [OUT_W-1:0]    r21_o,
  output logic [OUT_W-1:0]    r22_o,
  output logic [OUT_W-1:0]    r23_o,
  output logic [OUT_W-1:0]    r31_o,
  output logic [OUT_W-1:0]    r32_o,
  output logic [OUT_W-1:0]    r33_o,
  output logic                zero_input_o
);

  localparam int LAT = FRAC_BITS + 7;
  localparam int QW  = FRAC_BITS + 2;
  localparam int WW  = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;

  logic             accept;
  logic [LAT-1:0]   vld_q, vld_d;
  logic [LAT-2:0]   zr_q, zr_d;
  quat_t            quat;
  frac_t            frac;
  logic [QW-1:0]    quo [N_ENTRY];
  logic             neg [N_ENTRY];
  logic [N_ENTRY-1:0][OUT_W-1:0] ent_d, ent_q;
  logic             zero_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  qrm_prep #(.IN_WIDTH(IN_WIDTH)) u_prep (
    .clk_i    (clk_i),
    .comp_x_i (comp_x_i),
    .comp_y_i (comp_y_i),
    .comp_z_i (comp_z_i),
    .comp_w_i (comp_w_i),
    .quat_o   (quat)
  );

  qrm_prod u_prod (
    .clk_i  (clk_i),
    .quat_i (quat),
    .frac_o (frac)
  );

  for (genvar e = 0; e < N_ENTRY; e++) begin : g_lane
    qrm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i  (clk_i),
      .mag_i  (frac.mag[e]),
      .norm_i (frac.norm),
      .neg_i  (frac.neg[e]),
      .quo_o  (quo[e]),
      .neg_o  (neg[e])
    );
  end

  // Advance valid and zero flags alongside the data.
  assign vld_d = {vld_q[LAT-2:0], accept};
  assign zr_d  = {zr_q[LAT-3:0],
                  (comp_x_i == '0) && (comp_y_i == '0) &&
                  (comp_z_i == '0) && (comp_w_i == '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      zr_q  <= '0;
    end else begin
      vld_q <= vld_d;
      zr_q  <= zr_d;
    end
  end

  // Round half away from zero, clamp to one, apply sign, fall back to identity.
  always_comb begin
    logic [QW-1:0]        rnd;
    logic [QW-1:0]        sat;
    logic signed [QW:0]   sv;
    logic signed [WW-1:0] wv;
    for (int i = 0; i < N_ENTRY; i++) begin
      rnd = (quo[i] + 1'b1) >> 1;
      sat = (rnd > ONE_Q) ? ONE_Q : rnd;
      sv  = neg[i] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
      wv  = WW'(sv);
      if (zr_q[LAT-2]) begin
        ent_d[i] = (i == 0 || i == 4 || i == 8) ? ONE_W[OUT_W-1:0] : '0;
      end else begin
        ent_d[i] = wv[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    zero_q <= zr_q[LAT-2];
  end

  assign result_valid_o = vld_q[LAT-1];
  assign zero_input_o   = zero_q;
  assign r11_o = ent_q[0];
  assign r12_o = ent_q[1];
  assign r13_o = ent_q[2];
  assign r21_o = ent_q[3];
  assign r22_o = ent_q[4];
  assign r23_o = ent_q[5];
  assign r31_o = ent_q[6];
  assign r32_o = ent_q[7];
  assign r33_o = ent_q[8];

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT result_valid_o)
    else $error("transaction did not emerge after the pipeline latency");

  a_zero_offdiag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && zero_input_o) |->
      (r12_o == '0 && r13_o == '0 && r21_o == '0 && r23_o == '0 &&
       r31_o == '0 && r32_o == '0))
    else $error("zero quaternion gave non-identity off-diagonal");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && FRAC_BITS == 14) |->
      ($signed(r11_o) <= 16384 && $signed(r11_o) >= -16384 &&
       $signed(r22_o) <= 16384 && $signed(r22_o) >= -16384 &&
       $signed(r33_o) <= 16384 && $signed(r33_o) >= -16384))
    else $error("diagonal entry outside plus or minus one");

endmodule
